// File: hw/rtl/rfr_pkg.sv
// Package for the response frame receiver.
// Holds the framing constants, phase and status codes. No dependencies.
package rfr_pkg;

  localparam int unsigned MaxFrameData = 256;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 9;
  localparam int unsigned StatW  = 2;
  localparam int unsigned InW    = 24;
  localparam int unsigned OutW   = 24;

  localparam logic [ByteW-1:0] StartByte   = 8'h02;
  localparam logic [ByteW-1:0] FooterEnd   = 8'h03;
  localparam logic [ByteW-1:0] FooterBlock = 8'h17;
  localparam logic [LenW-1:0]  LenFull     = 9'd256;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_LENGTH = 3'd1,
    PH_DATA   = 3'd2,
    PH_CHECK  = 3'd3,
    PH_FOOTER = 3'd4
  } phase_e;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 2'd0,
    ST_FORMAT   = 2'd1,
    ST_LENGTH   = 2'd2,
    ST_CHECKSUM = 2'd3
  } status_e;

endpackage

// File: hw/rtl/response_frame_receiver_core.sv
// Response frame receiver: framing state machine with one output register.
// Depends on rfr_pkg.
//
// Usage:
//   Slave channel s_axis_* carries one received byte per item together with
//   the data length the caller expects (sampled at the length byte).
//   Master channel m_axis_* carries payload bytes (tlast low) as they arrive
//   and one status item (tlast high) that ends each frame: ok, format error,
//   length mismatch or checksum error, with the decoded frame length (zero after a bad start byte).
//   The consumer drops a frame's payload unless its status is ok.
//   Results are registered: a result appears in the output register in the
//   cycle after the input item that causes it is accepted.
//   Throughput: one byte per cycle unless the output register stalls; the phase
//   register and the running sum are updated in the same cycle the byte is taken.
//   Start, length-ok and checksum bytes give no result.
//   Stall: while a result waits in the output register and m_axis_tready is
//   low, s_axis_tready is low; it is high whenever the register is empty or
//   being emptied in the same cycle.
//   Reset: the receiver waits for a start byte, the output register is empty.
module response_frame_receiver_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [rfr_pkg::InW-1:0] s_axis_tdata,   // rx_byte[7:0], expected_length[16:8]
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [rfr_pkg::OutW-1:0] m_axis_tdata,  // data_byte[7:0], status[9:8],
                                                  // frame_length[18:10]
  output logic                    m_axis_tlast    // last
);

  rfr_pkg::phase_e                phase_q, phase_d;
  logic [rfr_pkg::LenW-1:0]       left_q, left_d;
  logic [rfr_pkg::ByteW-1:0]      sum_q, sum_d;
  logic [rfr_pkg::ByteW-1:0]      check_q, check_d;
  logic [rfr_pkg::LenW-1:0]       dlen_q, dlen_d;

  logic                           ovalid_q, ovalid_d;
  logic [rfr_pkg::ByteW-1:0]      odata_q, odata_d;
  rfr_pkg::status_e               ostat_q, ostat_d;
  logic [rfr_pkg::LenW-1:0]       olen_q, olen_d;
  logic                           olast_q, olast_d;

  logic                           accept;
  logic                           emit;
  logic [rfr_pkg::ByteW-1:0]      rx_byte;
  logic [rfr_pkg::LenW-1:0]       exp_len;
  logic [rfr_pkg::LenW-1:0]       len;
  logic [rfr_pkg::LenW-1:0]       left_dec;

  assign s_axis_tready = !ovalid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign rx_byte       = s_axis_tdata[7:0];
  assign exp_len       = s_axis_tdata[16:8];
  assign len           = (rx_byte == '0) ? rfr_pkg::LenFull : {1'b0, rx_byte};
  assign left_dec      = left_q - 9'd1;

  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    sum_d   = sum_q;
    check_d = check_q;
    dlen_d  = dlen_q;
    emit    = 1'b0;
    odata_d = '0;
    ostat_d = rfr_pkg::ST_OK;
    olen_d  = '0;
    olast_d = 1'b0;
    if (accept) begin
      case (phase_q)
        rfr_pkg::PH_LENGTH: begin
          dlen_d = len;
          if (len > rfr_pkg::LenW'(rfr_pkg::MaxFrameData)) begin
            phase_d = rfr_pkg::PH_START;
            emit    = 1'b1;
            ostat_d = rfr_pkg::ST_FORMAT;
            olen_d  = len;
            olast_d = 1'b1;
          end else if (len != exp_len) begin
            phase_d = rfr_pkg::PH_START;
            emit    = 1'b1;
            ostat_d = rfr_pkg::ST_LENGTH;
            olen_d  = len;
            olast_d = 1'b1;
          end else begin
            sum_d   = rx_byte;
            left_d  = len;
            phase_d = rfr_pkg::PH_DATA;
          end
        end
        rfr_pkg::PH_DATA: begin
          sum_d   = sum_q + rx_byte;
          left_d  = left_dec;
          if (left_dec == '0) phase_d = rfr_pkg::PH_CHECK;
          emit    = 1'b1;
          odata_d = rx_byte;
        end
        rfr_pkg::PH_CHECK: begin
          check_d = rx_byte;
          phase_d = rfr_pkg::PH_FOOTER;
        end
        rfr_pkg::PH_FOOTER: begin
          phase_d = rfr_pkg::PH_START;
          emit    = 1'b1;
          olen_d  = dlen_q;
          olast_d = 1'b1;
          if (rx_byte != rfr_pkg::FooterEnd && rx_byte != rfr_pkg::FooterBlock) begin
            ostat_d = rfr_pkg::ST_FORMAT;
          end else if (8'(-sum_q) != check_q) begin
            ostat_d = rfr_pkg::ST_CHECKSUM;
          end else begin
            ostat_d = rfr_pkg::ST_OK;
          end
        end
        default: begin
          // waiting for start; unused codes act the same
          if (rx_byte != rfr_pkg::StartByte) begin
            phase_d = rfr_pkg::PH_START;
            emit    = 1'b1;
            ostat_d = rfr_pkg::ST_FORMAT;
            olast_d = 1'b1;
          end else begin
            phase_d = rfr_pkg::PH_LENGTH;
          end
        end
      endcase
    end
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (m_axis_tready) ovalid_d = 1'b0;
    if (emit) ovalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= rfr_pkg::PH_START;
      left_q   <= '0;
      sum_q    <= '0;
      check_q  <= '0;
      dlen_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      left_q   <= left_d;
      sum_q    <= sum_d;
      check_q  <= check_d;
      dlen_q   <= dlen_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      odata_q <= odata_d;
      ostat_q <= ostat_d;
      olen_q  <= olen_d;
      olast_q <= olast_d;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {5'b0, olen_q, ostat_q, odata_q};
  assign m_axis_tlast  = olast_q;

endmodule

// File: hw/rtl/rfr_checker.sv
// Port-level checker for the response frame receiver, bound to response_frame_receiver_core.
// Depends on rfr_pkg and response_frame_receiver_core.
module rfr_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_tvalid_i,
  input logic                     s_tready_i,
  input logic                     m_tvalid_i,
  input logic                     m_tready_i,
  input logic [rfr_pkg::OutW-1:0] m_tdata_i,
  input logic                     m_tlast_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i) && $stable(m_tlast_i))
    else $error("result changed while stalled");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_tvalid_i |-> s_tready_i)
    else $error("input stalled with empty output register");

  a_data_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tlast_i |-> m_tdata_i[23:8] == '0)
    else $error("payload item carries status or length");

  a_new_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_i && !$past(m_tvalid_i)) |-> $past(s_tvalid_i && s_tready_i))
    else $error("result without an accepted item");

endmodule

bind response_frame_receiver_core rfr_checker u_rfr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid),
  .s_tready_i (s_axis_tready),
  .m_tvalid_i (m_axis_tvalid),
  .m_tready_i (m_axis_tready),
  .m_tdata_i  (m_axis_tdata),
  .m_tlast_i  (m_axis_tlast)
);
